FILE: hdl/frcs_pkg.sv
`timescale 1ns / 1ps

package frcs_pkg;

    localparam int CFG_W      = 32;
    localparam int DIFF_W     = 33;
    localparam int TAG_W      = 16;
    localparam int STAT_W     = 48;
    localparam int SUM_W      = 56;
    localparam int DOF_W      = 18;
    localparam int IN_DATA_W  = 272;
    localparam int OUT_DATA_W = 200;

    localparam logic [1:0] CFG_COEF_A     = 2'd0;
    localparam logic [1:0] CFG_COEF_B     = 2'd1;
    localparam logic [1:0] CFG_COEF_C     = 2'd2;
    localparam logic [1:0] CFG_NORM_SCALE = 2'd3;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [DOF_W-1:0]        DOF_MAX = {DOF_W{1'b1}};

    typedef struct packed {
        logic [CFG_W-1:0]        coef_a;
        logic [CFG_W-1:0]        coef_b;
        logic signed [CFG_W-1:0] coef_c;
        logic [CFG_W-1:0]        norm_scale;
    } t_coefs;

    // Differences of one bin plus its control flags.
    typedef struct packed {
        logic signed [DIFF_W-1:0] ra;
        logic signed [DIFF_W-1:0] ia;
        logic signed [DIFF_W-1:0] rb;
        logic signed [DIFF_W-1:0] ib;
        logic [TAG_W-1:0]         tag;
        logic                     last;
        logic                     start;
    } t_job;

    // Declared from the top bit down, so bin_stat lands in the lowest bits.
    typedef struct packed {
        logic [DOF_W-1:0]         best_dof;
        logic [TAG_W-1:0]         best_tag;
        logic signed [SUM_W-1:0]  best_total;
        logic signed [SUM_W-1:0]  run_total;
        logic signed [STAT_W-1:0] bin_stat;
    } t_result;

endpackage

FILE: hdl/frcs_front.sv
`timescale 1ns / 1ps

module frcs_front import frcs_pkg::*; (
    input  logic                 i_tvalid,
    output logic                 o_tready,
    // obs_re_a, obs_im_a, obs_re_b, obs_im_b, tpl_re_a, tpl_im_a, tpl_re_b, tpl_im_b, shift_tag
    input  logic [IN_DATA_W-1:0] i_tdata,
    input  logic                 i_tlast,
    // search_start
    input  logic                 i_tuser,
    input  logic                 i_q_full,
    output logic                 o_push,
    output t_job                 o_job
);

    logic signed [DIFF_W-1:0] obs [4];
    logic signed [DIFF_W-1:0] tpl [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            obs[i] = {i_tdata[32*i+31], i_tdata[32*i +: 32]};
            tpl[i] = {i_tdata[32*(i+4)+31], i_tdata[32*(i+4) +: 32]};
        end
    end

    assign o_tready = !i_q_full;
    assign o_push   = i_tvalid && !i_q_full;

    always_comb begin
        o_job.ra    = obs[0] - tpl[0];
        o_job.ia    = obs[1] - tpl[1];
        o_job.rb    = obs[2] - tpl[2];
        o_job.ib    = obs[3] - tpl[3];
        o_job.tag   = i_tdata[256 +: TAG_W];
        o_job.last  = i_tlast;
        o_job.start = i_tuser;
    end

endmodule

FILE: hdl/frcs_queue.sv
`timescale 1ns / 1ps

module frcs_queue import frcs_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

FILE: hdl/frcs_back.sv
`timescale 1ns / 1ps

module frcs_back import frcs_pkg::*; #(
    parameter int MAX_BINS = 65536
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_coefs  i_coefs,
    input  logic    i_q_valid,
    input  t_job    i_q_job,
    output logic    o_q_pop,
    input  logic    i_out_ready,
    output logic    o_out_valid,
    output logic    o_out_last,
    output t_result o_out
);

    localparam int CNT_CAP    = (MAX_BINS < 131071) ? MAX_BINS : 131071;
    localparam int CNT_W      = $clog2(CNT_CAP + 1);
    localparam int DOF_FULL_W = CNT_W + 2;
    localparam int DW         = (DOF_FULL_W > DOF_W) ? DOF_FULL_W : DOF_W;
    localparam int ACC_W      = 104;
    localparam int PART_W     = 68;
    localparam int PROD_W     = 2 * DIFF_W;

    // Sequencer steps: six squares and cross products, nine coefficient
    // products, rounding, three scale products, then saturation and bookkeeping.
    localparam logic [4:0] ST_FA_RR   = 5'd0;
    localparam logic [4:0] ST_FA_II   = 5'd1;
    localparam logic [4:0] ST_FB_RR   = 5'd2;
    localparam logic [4:0] ST_FB_II   = 5'd3;
    localparam logic [4:0] ST_FX_RR   = 5'd4;
    localparam logic [4:0] ST_FX_II   = 5'd5;
    localparam logic [4:0] ST_QB0     = 5'd6;
    localparam logic [4:0] ST_QB1     = 5'd7;
    localparam logic [4:0] ST_QB2     = 5'd8;
    localparam logic [4:0] ST_QA0     = 5'd9;
    localparam logic [4:0] ST_QA1     = 5'd10;
    localparam logic [4:0] ST_QA2     = 5'd11;
    localparam logic [4:0] ST_QC0     = 5'd12;
    localparam logic [4:0] ST_QC1     = 5'd13;
    localparam logic [4:0] ST_QC2     = 5'd14;
    localparam logic [4:0] ST_WAIT_Q  = 5'd15;
    localparam logic [4:0] ST_ROUND_Q = 5'd16;
    localparam logic [4:0] ST_P0      = 5'd17;
    localparam logic [4:0] ST_P1      = 5'd18;
    localparam logic [4:0] ST_P2      = 5'd19;
    localparam logic [4:0] ST_WAIT_P  = 5'd20;
    localparam logic [4:0] ST_SAT     = 5'd21;
    localparam logic [4:0] ST_ACC     = 5'd22;
    localparam logic [4:0] ST_FINISH  = 5'd23;
    localparam logic [4:0] ST_IDLE    = 5'd24;

    localparam logic [2:0] DST_NONE = 3'd0;
    localparam logic [2:0] DST_FA2  = 3'd1;
    localparam logic [2:0] DST_FB2  = 3'd2;
    localparam logic [2:0] DST_FAB  = 3'd3;
    localparam logic [2:0] DST_Q    = 3'd4;
    localparam logic [2:0] DST_P    = 3'd5;

    localparam logic [1:0] CHUNK_LO  = 2'd0;
    localparam logic [1:0] CHUNK_MID = 2'd1;
    localparam logic [1:0] CHUNK_HI  = 2'd2;

    localparam logic signed [ACC_W-1:0] RND32 = ACC_W'(64'h0000_0000_8000_0000);
    localparam logic signed [ACC_W-1:0] RND16 = ACC_W'(64'h0000_0000_0000_8000);

    typedef struct packed {
        logic [2:0] dst;
        logic       load;
        logic [1:0] k;
        logic       dbl;
        logic       sub;
    } t_mctl;

    // Slice of a 68-bit value for the shared multiplier: two unsigned 32-bit
    // words and a signed top part.
    function automatic logic signed [DIFF_W-1:0] chunk(input logic signed [PART_W-1:0] v,
                                                       input logic [1:0] k);
        logic signed [DIFF_W-1:0] c;
        case (k)
            CHUNK_LO:  c = {1'b0, v[31:0]};
            CHUNK_MID: c = {1'b0, v[63:32]};
            CHUNK_HI:  c = {{29{v[67]}}, v[67:64]};
            default:   c = '0;
        endcase
        return c;
    endfunction

    logic [4:0]                r_step, n_step;
    t_job                      r_job;
    t_mctl                     r_mctl, n_mctl;
    logic signed [DIFF_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   prod_ext, shifted, addend;
    logic signed [PART_W-1:0]  r_fa2, r_fb2, r_fab, r_qr;
    logic signed [ACC_W-1:0]   r_q, r_p, q_rnd, p_rnd, acc_base, acc_sum;
    logic [87:0]               p_sh;
    logic signed [STAT_W-1:0]  r_stat, stat_sat;
    logic signed [SUM_W:0]     run_wide;
    logic signed [SUM_W-1:0]   run_sat;
    logic signed [SUM_W-1:0]   r_acc;
    logic [CNT_W-1:0]          r_cnt;
    logic signed [SUM_W-1:0]   r_min, min_eff, min_new;
    logic [TAG_W-1:0]          r_min_tag, tag_eff, tag_new;
    logic [DOF_W-1:0]          r_min_dof, dof_eff, dof_new, dof_sat;
    logic [DOF_FULL_W-1:0]     dof_full;
    logic [DW-1:0]             dof_ext;
    logic                      take;
    logic                      fin_fire;
    logic                      r_ovalid;
    logic                      r_olast;
    t_result                   r_out;

    assign o_q_pop     = (r_step == ST_IDLE) && i_q_valid;
    assign fin_fire    = (r_step == ST_FINISH) && (!r_ovalid || i_out_ready);
    assign o_out_valid = r_ovalid;
    assign o_out_last  = r_olast;
    assign o_out       = r_out;

    always_comb begin
        n_step = r_step;
        case (r_step)
            ST_IDLE: begin
                if (i_q_valid) begin
                    n_step = ST_FA_RR;
                end
            end
            ST_FINISH: begin
                if (fin_fire) begin
                    n_step = ST_IDLE;
                end
            end
            default: begin
                if (r_step inside {[ST_FA_RR:ST_ACC]}) begin
                    n_step = r_step + 5'd1;
                end else begin
                    n_step = ST_IDLE;
                end
            end
        endcase
    end

    // Operand selection for the shared 33x33 multiplier.
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        n_mctl = '{dst: DST_NONE, load: 1'b0, k: CHUNK_LO, dbl: 1'b0, sub: 1'b0};
        case (r_step)
            ST_FA_RR: begin
                mul_a = r_job.ra; mul_b = r_job.ra; n_mctl.dst = DST_FA2; n_mctl.load = 1'b1;
            end
            ST_FA_II: begin
                mul_a = r_job.ia; mul_b = r_job.ia; n_mctl.dst = DST_FA2;
            end
            ST_FB_RR: begin
                mul_a = r_job.rb; mul_b = r_job.rb; n_mctl.dst = DST_FB2; n_mctl.load = 1'b1;
            end
            ST_FB_II: begin
                mul_a = r_job.ib; mul_b = r_job.ib; n_mctl.dst = DST_FB2;
            end
            ST_FX_RR: begin
                mul_a = r_job.ra; mul_b = r_job.rb; n_mctl.dst = DST_FAB; n_mctl.load = 1'b1;
            end
            ST_FX_II: begin
                mul_a = r_job.ia; mul_b = r_job.ib; n_mctl.dst = DST_FAB;
            end
            ST_QB0, ST_QB1, ST_QB2: begin
                n_mctl.k    = (r_step == ST_QB0) ? CHUNK_LO :
                              (r_step == ST_QB1) ? CHUNK_MID : CHUNK_HI;
                mul_a       = chunk(r_fa2, n_mctl.k);
                mul_b       = {1'b0, i_coefs.coef_b};
                n_mctl.dst  = DST_Q;
                n_mctl.load = (r_step == ST_QB0);
            end
            ST_QA0, ST_QA1, ST_QA2: begin
                n_mctl.k   = (r_step == ST_QA0) ? CHUNK_LO :
                             (r_step == ST_QA1) ? CHUNK_MID : CHUNK_HI;
                mul_a      = chunk(r_fb2, n_mctl.k);
                mul_b      = {1'b0, i_coefs.coef_a};
                n_mctl.dst = DST_Q;
            end
            ST_QC0, ST_QC1, ST_QC2: begin
                // The cross term enters as minus twice C times Re(Fa Fb*).
                n_mctl.k   = (r_step == ST_QC0) ? CHUNK_LO :
                             (r_step == ST_QC1) ? CHUNK_MID : CHUNK_HI;
                mul_a      = chunk(r_fab, n_mctl.k);
                mul_b      = {i_coefs.coef_c[CFG_W-1], i_coefs.coef_c};
                n_mctl.dst = DST_Q;
                n_mctl.dbl = 1'b1;
                n_mctl.sub = 1'b1;
            end
            ST_P0, ST_P1, ST_P2: begin
                n_mctl.k    = (r_step == ST_P0) ? CHUNK_LO :
                              (r_step == ST_P1) ? CHUNK_MID : CHUNK_HI;
                mul_a       = chunk(r_qr, n_mctl.k);
                mul_b       = {1'b0, i_coefs.norm_scale};
                n_mctl.dst  = DST_P;
                n_mctl.load = (r_step == ST_P0);
            end
            default: ;
        endcase
    end

    // Weighting of the registered product, in the cycle after the multiplier operands are selected.
    always_comb begin
        prod_ext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
        case (r_mctl.k)
            CHUNK_MID: shifted = prod_ext <<< 32;
            CHUNK_HI:  shifted = prod_ext <<< 64;
            default:   shifted = prod_ext;
        endcase
        if (r_mctl.dbl) begin
            shifted = shifted <<< 1;
        end
        addend = shifted ^ {ACC_W{r_mctl.sub}};
        case (r_mctl.dst)
            DST_FA2: acc_base = {{(ACC_W-PART_W){r_fa2[PART_W-1]}}, r_fa2};
            DST_FB2: acc_base = {{(ACC_W-PART_W){r_fb2[PART_W-1]}}, r_fb2};
            DST_FAB: acc_base = {{(ACC_W-PART_W){r_fab[PART_W-1]}}, r_fab};
            DST_Q:   acc_base = r_q;
            DST_P:   acc_base = r_p;
            default: acc_base = '0;
        endcase
        if (r_mctl.load) begin
            acc_base = '0;
        end
        acc_sum = acc_base + addend + ACC_W'(r_mctl.sub);
    end

    always_comb begin
        q_rnd = r_q + RND32;
        p_rnd = r_p + RND16;
        p_sh  = p_rnd[ACC_W-1:16];
        if ((&p_sh[87:STAT_W-1]) || !(|p_sh[87:STAT_W-1])) begin
            stat_sat = p_sh[STAT_W-1:0];
        end else if (p_sh[87]) begin
            stat_sat = {1'b1, {(STAT_W-1){1'b0}}};
        end else begin
            stat_sat = {1'b0, {(STAT_W-1){1'b1}}};
        end
    end

    always_comb begin
        run_wide = {r_acc[SUM_W-1], r_acc} + {{(SUM_W+1-STAT_W){r_stat[STAT_W-1]}}, r_stat};
        if (run_wide[SUM_W] == run_wide[SUM_W-1]) begin
            run_sat = run_wide[SUM_W-1:0];
        end else if (run_wide[SUM_W]) begin
            run_sat = ~SUM_MAX;
        end else begin
            run_sat = SUM_MAX;
        end
    end

    always_comb begin
        dof_full = {r_cnt, 2'b00} - DOF_FULL_W'(4);
        dof_ext  = DW'(dof_full);
        dof_sat  = (dof_ext > DW'(DOF_MAX)) ? DOF_MAX : dof_ext[DOF_W-1:0];
        // A search start clears the best before this bin is compared.
        min_eff  = r_job.start ? SUM_MAX : r_min;
        tag_eff  = r_job.start ? '0 : r_min_tag;
        dof_eff  = r_job.start ? '0 : r_min_dof;
        take     = r_job.last && (r_acc < min_eff);
        min_new  = take ? r_acc     : min_eff;
        tag_new  = take ? r_job.tag : tag_eff;
        dof_new  = take ? dof_sat   : dof_eff;
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (o_q_pop) begin
            r_job <= i_q_job;
        end
        case (r_mctl.dst)
            DST_FA2: r_fa2 <= acc_sum[PART_W-1:0];
            DST_FB2: r_fb2 <= acc_sum[PART_W-1:0];
            DST_FAB: r_fab <= acc_sum[PART_W-1:0];
            DST_Q:   r_q   <= acc_sum;
            DST_P:   r_p   <= acc_sum;
            default: ;
        endcase
        if (r_step == ST_ROUND_Q) begin
            r_qr <= q_rnd[99:32];
        end
        if (r_step == ST_SAT) begin
            r_stat <= stat_sat;
        end
        if (fin_fire) begin
            r_out.bin_stat   <= r_stat;
            r_out.run_total  <= r_acc;
            r_out.best_total <= min_new;
            r_out.best_tag   <= tag_new;
            r_out.best_dof   <= dof_new;
            r_olast          <= r_job.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= ST_IDLE;
            r_mctl    <= '{dst: DST_NONE, load: 1'b0, k: CHUNK_LO, dbl: 1'b0, sub: 1'b0};
            r_acc     <= '0;
            r_cnt     <= '0;
            r_min     <= SUM_MAX;
            r_min_tag <= '0;
            r_min_dof <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_step <= n_step;
            r_mctl <= n_mctl;
            if (r_step == ST_ACC) begin
                r_acc <= run_sat;
                if (r_cnt < CNT_W'(CNT_CAP)) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            if (fin_fire) begin
                r_min     <= min_new;
                r_min_tag <= tag_new;
                r_min_dof <= dof_new;
                if (r_job.last) begin
                    r_acc <= '0;
                    r_cnt <= '0;
                end
            end
            if (fin_fire) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_dof_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (r_out.best_dof[1:0] == 2'b00 || r_out.best_dof == DOF_MAX))
        else $error("best degrees of freedom are not of the form 4n-4");

    a_best_not_above_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fin_fire && r_job.last) |=> ($signed(r_out.best_total) <= $signed(r_out.run_total)))
        else $error("best sum exceeds the run sum that just closed");

    a_run_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fin_fire && r_job.last) |=> (r_acc == '0 && r_cnt == '0))
        else $error("run sum or bin count not cleared after closing a run");
`endif

endmodule

FILE: hdl/fstat_residual_chi_square_core.sv
`timescale 1ns / 1ps
// The back end's single shared 33x33 multiplier runs 18 partial products plus rounding and
// accumulate steps per bin, and a new bin is taken only once the last result is registered.
// A two-item queue lets the input side keep accepting while a result waits on the output.
// Synchronous active-low reset clears coefficients, run sum, bin count, queue and
// output valid, and sets the best sum to the largest positive value.

module fstat_residual_chi_square_core import frcs_pkg::*; #(
    parameter int MAX_BINS = 65536
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // obs_re_a, obs_im_a, obs_re_b, obs_im_b, tpl_re_a, tpl_im_a, tpl_re_b, tpl_im_b, shift_tag
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tlast,
    // search_start
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // bin_stat, run_total, best_total, best_tag, best_dof, zero fill
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast
);

    t_coefs  r_coefs;
    logic    q_full, q_push, q_pop, q_valid;
    t_job    front_job, q_job;
    t_result result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COEF_A:     r_coefs.coef_a     <= i_cfg_data;
                CFG_COEF_B:     r_coefs.coef_b     <= i_cfg_data;
                CFG_COEF_C:     r_coefs.coef_c     <= i_cfg_data;
                CFG_NORM_SCALE: r_coefs.norm_scale <= i_cfg_data;
                default: ;
            endcase
        end
    end

    frcs_front u_front (
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_tdata  (s_axis_tdata),
        .i_tlast  (s_axis_tlast),
        .i_tuser  (s_axis_tuser),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_job    (front_job)
    );

    frcs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    frcs_back #(
        .MAX_BINS (MAX_BINS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_coefs     (r_coefs),
        .i_q_valid   (q_valid),
        .i_q_job     (q_job),
        .o_q_pop     (q_pop),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_last  (m_axis_tlast),
        .o_out       (result)
    );

    assign m_axis_tdata = OUT_DATA_W'(result);

endmodule
